// ===== rtl/core/wag_pkg.sv =====
// ----------------------------------------------------------------------------
// Waypoint attitude guidance package
// Shared codes, command and status structs, constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package wag_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WP_X = 2'd0;
	localparam logic [1:0] CFG_WP_Y = 2'd1;
	localparam logic [1:0] CFG_WP_Z = 2'd2;

	localparam logic signed [31:0] WP_X_RST = 32'sd1536000;
	localparam logic signed [31:0] WP_Y_RST = 32'sd460800;
	localparam logic signed [31:0] WP_Z_RST = -32'sd2048000;

	// Angles in rad * 2^20.
	localparam logic signed [24:0] ANG_PI      = 25'sd3294199;
	localparam logic signed [24:0] ANG_TWO_PI  = 25'sd6588398;
	localparam logic signed [23:0] ANG_HALF_PI = 24'sd1647099;

	localparam logic [15:0] THR_RST = 16'd19661;

	typedef enum logic [4:0] {
		OP_NONE, OP_PREP, OP_MAC, OP_MAC_CLR, OP_SQRT, OP_DIST, OP_HORIZ,
		OP_SPEED, OP_FX, OP_FZ, OP_ANG, OP_CUR, OP_DES, OP_PIT,
		OP_TGT1, OP_TGT2, OP_TGT3, OP_UPD
	} op_t;

	typedef enum logic [3:0] {
		MS_DA, MS_DB, MS_DC, MS_HA, MS_HC, MS_VX, MS_VY, MS_VZ,
		MS_QXZ, MS_QWY, MS_QXX, MS_QYY
	} msel_t;

	typedef enum logic [1:0] {
		AS_CUR, AS_DES, AS_PIT
	} asel_t;

	typedef struct packed {
		logic  load;
		op_t   op;
		msel_t msel;
		asel_t asel;
	} cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic cordic_busy;
	} sts_t;

	function automatic logic [19:0] atan_entry(input logic [4:0] i);
		logic [19:0] r;
		case (i)
			5'd0:  r = 20'd823550;
			5'd1:  r = 20'd486170;
			5'd2:  r = 20'd256879;
			5'd3:  r = 20'd130396;
			5'd4:  r = 20'd65451;
			5'd5:  r = 20'd32757;
			5'd6:  r = 20'd16383;
			5'd7:  r = 20'd8192;
			5'd8:  r = 20'd4096;
			5'd9:  r = 20'd2048;
			5'd10: r = 20'd1024;
			5'd11: r = 20'd512;
			5'd12: r = 20'd256;
			5'd13: r = 20'd128;
			5'd14: r = 20'd64;
			5'd15: r = 20'd32;
			5'd16: r = 20'd16;
			5'd17: r = 20'd8;
			5'd18: r = 20'd4;
			5'd19: r = 20'd2;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wag_sqrt.sv =====
// ----------------------------------------------------------------------------
// Iterative square root
// Floor root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wag_sqrt
	import wag_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] n_in,
	output logic             busy,
	output logic [31:0]      root
);

	logic        busy_q;
	logic [4:0]  k_q;
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [5:0]  sh;
	logic [63:0] bitv;
	logic [63:0] trial;

	always_comb begin
		sh    = 6'd62 - {k_q, 1'b0};
		bitv  = 64'd1 << sh;
		trial = res_q + bitv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (busy_q) begin
			k_q <= k_q + 5'd1;
			if (k_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n_in;
			res_q <= '0;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bitv;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign busy = busy_q;
	assign root = res_q[31:0];

endmodule

`default_nettype wire

// ===== rtl/core/wag_cordic.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Four-quadrant arctangent in rad * 2^20 with input normalisation.
// ----------------------------------------------------------------------------
`default_nettype none

module wag_cordic
	import wag_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [35:0] y_in,
	input  wire logic signed [35:0] x_in,
	output logic                    busy,
	output logic signed [23:0]      angle
);

	typedef enum logic [1:0] {P_IDLE, P_NORM, P_ITER, P_FIN} phase_t;

	phase_t             phase_q;
	logic [35:0]        ax_q, ay_q;
	logic               xneg_q, yneg_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [23:0] z_q;
	logic [4:0]         i_q;
	logic signed [23:0] angle_q;
	logic [35:0]        orv;
	logic signed [23:0] tab;
	logic signed [23:0] zc;
	logic signed [23:0] quad;

	always_comb begin
		orv  = ax_q | ay_q;
		tab  = $signed({4'd0, atan_entry(i_q)});
		if (z_q < 24'sd0) begin
			zc = 24'sd0;
		end else if (z_q > ANG_HALF_PI) begin
			zc = ANG_HALF_PI;
		end else begin
			zc = z_q;
		end
		quad = xneg_q ? (24'(ANG_PI) - zc) : zc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			i_q     <= '0;
		end else begin
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_NORM;
					end
				end
				P_NORM: begin
					if (orv == 36'd0) begin
						phase_q <= P_IDLE;
					end else if (orv[35:30] == 6'd0 && orv[29]) begin
						phase_q <= P_ITER;
						i_q     <= '0;
					end
				end
				P_ITER: begin
					i_q <= i_q + 5'd1;
					if (i_q == 5'd19) begin
						phase_q <= P_FIN;
					end
				end
				P_FIN: begin
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				if (start) begin
					ax_q   <= x_in[35] ? 36'(-x_in) : 36'(x_in);
					ay_q   <= y_in[35] ? 36'(-y_in) : 36'(y_in);
					xneg_q <= x_in[35];
					yneg_q <= y_in[35];
				end
			end
			P_NORM: begin
				if (orv == 36'd0) begin
					angle_q <= 24'sd0;
				end else if (orv[35:30] != 6'd0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (!orv[29]) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end else begin
					cx_q <= $signed({4'd0, ax_q[29:0]});
					cy_q <= $signed({4'd0, ay_q[29:0]});
					z_q  <= 24'sd0;
				end
			end
			P_ITER: begin
				if (cy_q >= 34'sd0) begin
					cx_q <= cx_q + (cy_q >>> i_q);
					cy_q <= cy_q - (cx_q >>> i_q);
					z_q  <= z_q + tab;
				end else begin
					cx_q <= cx_q - (cy_q >>> i_q);
					cy_q <= cy_q + (cx_q >>> i_q);
					z_q  <= z_q - tab;
				end
			end
			P_FIN: begin
				angle_q <= yneg_q ? -quad : quad;
			end
			default: ;
		endcase
	end

	assign busy  = (phase_q != P_IDLE);
	assign angle = angle_q;

endmodule

`default_nettype wire

// ===== rtl/core/wag_dp.sv =====
// ----------------------------------------------------------------------------
// Guidance datapath
// Operand registers, shared multiplier, root and arctangent units, targets.
// ----------------------------------------------------------------------------
`default_nettype none

module wag_dp
	import wag_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [19:0] vel_x,
	input  wire logic signed [19:0] vel_y,
	input  wire logic signed [19:0] vel_z,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic [12:0]        step_time,
	output logic signed [14:0]      pitch_out,
	output logic signed [14:0]      roll_out,
	output logic signed [14:0]      yaw_rate_out,
	output logic [15:0]             throttle_out,
	output logic [31:0]             distance_out
);

	logic signed [31:0] wx_q, wy_q, wz_q;
	logic signed [32:0] dx_q, dy_q, dz_q;
	logic signed [19:0] vx_q, vy_q, vz_q;
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic [12:0]        dt_q;
	logic [30:0]        da_q, db_q, dc_q, ha_q, hc_q;
	logic [1:0]         sd_q, sh_q;
	logic signed [64:0] acc_q;
	logic [33:0]        dist_q, horiz_q;
	logic [19:0]        speed_q;
	logic               fast_q;
	logic signed [35:0] fx_q, fz_q;
	logic signed [23:0] cur_q, des_q, pit_q;
	logic signed [24:0] err_q;
	logic signed [39:0] thr_p_q;
	logic [8:0]         pstep_q, rstep_q;
	logic [9:0]         tstep_q;
	logic signed [37:0] roll_p_q, yaw_p_q;
	logic signed [14:0] ptgt_q, rtgt_q, ytgt_q;
	logic [15:0]        ttgt_q;
	logic signed [14:0] pcmd_q, rcmd_q, yaw_q;
	logic [15:0]        tcmd_q;
	logic [31:0]        dout_q;

	logic [32:0]        ma, mb, mc, or_d, or_h;
	logic [1:0]         sd, sh;
	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod;
	logic [31:0]        root;
	logic               sqrt_busy;
	logic signed [35:0] ang_y, ang_x;
	logic signed [23:0] angle;
	logic               cordic_busy;
	logic [33:0]        hd;
	logic signed [24:0] ediff, ewrap;
	logic signed [20:0] tsd;
	logic [24:0]        pp, rp;
	logic signed [37:0] rr, yr;
	logic signed [18:0] rr_s, yr_s;
	logic signed [16:0] pr_s;
	logic signed [39:0] tr;
	logic signed [23:0] tr_s;
	logic signed [24:0] thr_t;
	logic               near;
	logic signed [17:0] pd, pdc, pn, rd, rdc, rn;
	logic signed [17:0] td, tdc, tn;

	// Magnitudes and pre-shift so that the squares stay within 64 bits.
	always_comb begin
		ma   = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
		mb   = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
		mc   = dz_q[32] ? 33'(-dz_q) : 33'(dz_q);
		or_d = ma | mb | mc;
		or_h = ma | mc;
		sd   = or_d[32] ? 2'd2 : (or_d[31] ? 2'd1 : 2'd0);
		sh   = or_h[32] ? 2'd2 : (or_h[31] ? 2'd1 : 2'd0);
	end

	always_comb begin
		case (cmd.msel)
			MS_DA:   begin op_a = $signed({2'b0, da_q}); op_b = op_a; end
			MS_DB:   begin op_a = $signed({2'b0, db_q}); op_b = op_a; end
			MS_DC:   begin op_a = $signed({2'b0, dc_q}); op_b = op_a; end
			MS_HA:   begin op_a = $signed({2'b0, ha_q}); op_b = op_a; end
			MS_HC:   begin op_a = $signed({2'b0, hc_q}); op_b = op_a; end
			MS_VX:   begin op_a = 33'(vx_q); op_b = op_a; end
			MS_VY:   begin op_a = 33'(vy_q); op_b = op_a; end
			MS_VZ:   begin op_a = 33'(vz_q); op_b = op_a; end
			MS_QXZ:  begin op_a = 33'(qx_q); op_b = 33'(qz_q); end
			MS_QWY:  begin op_a = 33'(qw_q); op_b = 33'(qy_q); end
			MS_QXX:  begin op_a = 33'(qx_q); op_b = op_a; end
			MS_QYY:  begin op_a = 33'(qy_q); op_b = op_a; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		prod = op_a * op_b;
	end

	always_comb begin
		hd = (horiz_q < 34'd256) ? 34'd256 : horiz_q;
		case (cmd.asel)
			AS_CUR: begin
				if (fast_q) begin
					ang_y = 36'(vx_q);
					ang_x = -36'(vz_q);
				end else begin
					ang_y = fx_q;
					ang_x = fz_q;
				end
			end
			AS_DES:  begin ang_y = 36'(dx_q); ang_x = -36'(dz_q); end
			AS_PIT:  begin ang_y = 36'(dy_q); ang_x = $signed({2'b0, hd}); end
			default: begin ang_y = '0; ang_x = '0; end
		endcase
	end

	wag_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQRT),
		.n_in   (acc_q[63:0]),
		.busy   (sqrt_busy),
		.root   (root)
	);

	wag_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_ANG),
		.y_in   (ang_y),
		.x_in   (ang_x),
		.busy   (cordic_busy),
		.angle  (angle)
	);

	// Heading error wrap, target rounding and the slew of the held commands.
	always_comb begin
		ediff = 25'(des_q) - 25'(cur_q);
		if (ediff > ANG_PI) begin
			ewrap = ediff - ANG_TWO_PI;
		end else if (ediff < -ANG_PI) begin
			ewrap = ediff + ANG_TWO_PI;
		end else begin
			ewrap = ediff;
		end
		tsd  = ((dist_q > 34'd307200) ? 21'sd48640 : 21'sd39680) - $signed({1'b0, speed_q});
		pp   = 25'(dt_q) * 25'd2574;
		rp   = 25'(dt_q) * 25'd4003;
		rr   = roll_p_q + 38'sd262144;
		yr   = yaw_p_q + 38'sd262144;
		rr_s = 19'(rr >>> 19);
		yr_s = 19'(yr >>> 19);
		pr_s = 17'((25'(pit_q) + 25'sd64) >>> 7);
		tr   = thr_p_q + 40'sd32768;
		tr_s = 24'(tr >>> 16);
		thr_t = 25'sd18350 + 25'(tr_s);
		near = (dist_q < 34'd30720);

		pd  = 18'(ptgt_q) - 18'(pcmd_q);
		pdc = (pd > $signed({9'd0, pstep_q})) ? $signed({9'd0, pstep_q}) :
		      ((pd < -$signed({9'd0, pstep_q})) ? -$signed({9'd0, pstep_q}) : pd);
		pn  = 18'(pcmd_q) + pdc;
		rd  = 18'(rtgt_q) - 18'(rcmd_q);
		rdc = (rd > $signed({9'd0, rstep_q})) ? $signed({9'd0, rstep_q}) :
		      ((rd < -$signed({9'd0, rstep_q})) ? -$signed({9'd0, rstep_q}) : rd);
		rn  = 18'(rcmd_q) + rdc;
		td  = $signed({2'b0, ttgt_q}) - $signed({2'b0, tcmd_q});
		tdc = (td > $signed({8'd0, tstep_q})) ? $signed({8'd0, tstep_q}) :
		      ((td < -$signed({8'd0, tstep_q})) ? -$signed({8'd0, tstep_q}) : td);
		tn  = $signed({2'b0, tcmd_q}) + tdc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q   <= WP_X_RST;
			wy_q   <= WP_Y_RST;
			wz_q   <= WP_Z_RST;
			pcmd_q <= '0;
			rcmd_q <= '0;
			tcmd_q <= THR_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WP_X: wx_q <= $signed(cfg_data);
					CFG_WP_Y: wy_q <= $signed(cfg_data);
					CFG_WP_Z: wz_q <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (cmd.op == OP_UPD) begin
				pcmd_q <= (pn > 18'sd4289) ? 15'sd4289 :
				          ((pn < -18'sd4289) ? -15'sd4289 : 15'(pn));
				rcmd_q <= (rn > 18'sd7149) ? 15'sd7149 :
				          ((rn < -18'sd7149) ? -15'sd7149 : 15'(rn));
				tcmd_q <= (tn > 18'sd32768) ? 16'd32768 :
				          ((tn < 18'sd0) ? 16'd0 : 16'(tn));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= 33'(wx_q) - 33'(pos_x);
			dy_q <= 33'(wy_q) - 33'(pos_y);
			dz_q <= 33'(wz_q) - 33'(pos_z);
			vx_q <= vel_x;
			vy_q <= vel_y;
			vz_q <= vel_z;
			qw_q <= quat_w;
			qx_q <= quat_x;
			qy_q <= quat_y;
			qz_q <= quat_z;
			dt_q <= step_time;
		end
		case (cmd.op)
			OP_PREP: begin
				da_q <= 31'(ma >> sd);
				db_q <= 31'(mb >> sd);
				dc_q <= 31'(mc >> sd);
				ha_q <= 31'(ma >> sh);
				hc_q <= 31'(mc >> sh);
				sd_q <= sd;
				sh_q <= sh;
			end
			OP_MAC:     acc_q <= acc_q + $signed(prod[64:0]);
			OP_MAC_CLR: acc_q <= $signed(prod[64:0]);
			OP_DIST:    dist_q <= 34'(root) << sd_q;
			OP_HORIZ:   horiz_q <= 34'(root) << sh_q;
			OP_SPEED: begin
				speed_q <= root[19:0];
				fast_q  <= (acc_q > 65'sd26214400);
			end
			OP_FX:  fx_q <= -(36'(acc_q) <<< 1);
			OP_FZ:  fz_q <= 36'sd268435456 - (36'(acc_q) <<< 1);
			OP_CUR: cur_q <= angle;
			OP_DES: des_q <= angle;
			OP_PIT: pit_q <= angle;
			OP_TGT1: begin
				err_q   <= ewrap;
				thr_p_q <= 40'(tsd) * 40'sd41943;
				pstep_q <= 9'(pp >> 16);
				rstep_q <= 9'(rp >> 16);
				tstep_q <= 10'(dt_q >> 3);
			end
			OP_TGT2: begin
				roll_p_q <= 38'(err_q) * 38'sd6554;
				yaw_p_q  <= 38'(err_q) * 38'sd4915;
			end
			OP_TGT3: begin
				if (near) begin
					ptgt_q <= '0;
					rtgt_q <= '0;
					ytgt_q <= '0;
					ttgt_q <= 16'd14746;
				end else begin
					ptgt_q <= (pr_s > 17'sd1716) ? 15'sd1716 :
					          ((pr_s < -17'sd1716) ? -15'sd1716 : 15'(pr_s));
					rtgt_q <= (rr_s > 19'sd5004) ? 15'sd5004 :
					          ((rr_s < -19'sd5004) ? -15'sd5004 : 15'(rr_s));
					ytgt_q <= (yr_s > 19'sd2002) ? 15'sd2002 :
					          ((yr_s < -19'sd2002) ? -15'sd2002 : 15'(yr_s));
					ttgt_q <= (thr_t > 25'sd29491) ? 16'd29491 :
					          ((thr_t < 25'sd11469) ? 16'd11469 : 16'(thr_t));
				end
			end
			OP_UPD: begin
				yaw_q  <= ytgt_q;
				dout_q <= (dist_q[33:32] != 2'd0) ? 32'hFFFF_FFFF : dist_q[31:0];
			end
			default: ;
		endcase
	end

	assign sts.sqrt_busy   = sqrt_busy;
	assign sts.cordic_busy = cordic_busy;
	assign pitch_out       = pcmd_q;
	assign roll_out        = rcmd_q;
	assign yaw_rate_out    = yaw_q;
	assign throttle_out    = tcmd_q;
	assign distance_out    = dout_q;

endmodule

`default_nettype wire

// ===== rtl/core/wag_ctrl.sv =====
// ----------------------------------------------------------------------------
// Guidance controller
// Sequences the datapath through one word and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module wag_ctrl
	import wag_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_IDLE, S_PREP, S_DA, S_DB, S_DC, S_DSQ, S_DW,
		S_HA, S_HC, S_HSQ, S_HW, S_VX, S_VY, S_VZ, S_VSQ, S_VW,
		S_Q1, S_Q2, S_QS1, S_Q3, S_Q4, S_QS2,
		S_AC, S_ACW, S_AD, S_ADW, S_AP, S_APW,
		S_T1, S_T2, S_T3, S_UPD
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.op   = OP_NONE;
		cmd.msel = MS_DA;
		cmd.asel = AS_CUR;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_PREP;
			S_PREP: begin cmd.op = OP_PREP; state_d = S_DA; end
			S_DA: begin cmd.op = OP_MAC_CLR; cmd.msel = MS_DA; state_d = S_DB; end
			S_DB: begin cmd.op = OP_MAC; cmd.msel = MS_DB; state_d = S_DC; end
			S_DC: begin cmd.op = OP_MAC; cmd.msel = MS_DC; state_d = S_DSQ; end
			S_DSQ: begin cmd.op = OP_SQRT; state_d = S_DW; end
			S_DW: begin
				if (!sts.sqrt_busy) begin cmd.op = OP_DIST; state_d = S_HA; end
			end
			S_HA: begin cmd.op = OP_MAC_CLR; cmd.msel = MS_HA; state_d = S_HC; end
			S_HC: begin cmd.op = OP_MAC; cmd.msel = MS_HC; state_d = S_HSQ; end
			S_HSQ: begin cmd.op = OP_SQRT; state_d = S_HW; end
			S_HW: begin
				if (!sts.sqrt_busy) begin cmd.op = OP_HORIZ; state_d = S_VX; end
			end
			S_VX: begin cmd.op = OP_MAC_CLR; cmd.msel = MS_VX; state_d = S_VY; end
			S_VY: begin cmd.op = OP_MAC; cmd.msel = MS_VY; state_d = S_VZ; end
			S_VZ: begin cmd.op = OP_MAC; cmd.msel = MS_VZ; state_d = S_VSQ; end
			S_VSQ: begin cmd.op = OP_SQRT; state_d = S_VW; end
			S_VW: begin
				if (!sts.sqrt_busy) begin cmd.op = OP_SPEED; state_d = S_Q1; end
			end
			S_Q1: begin cmd.op = OP_MAC_CLR; cmd.msel = MS_QXZ; state_d = S_Q2; end
			S_Q2: begin cmd.op = OP_MAC; cmd.msel = MS_QWY; state_d = S_QS1; end
			S_QS1: begin cmd.op = OP_FX; state_d = S_Q3; end
			S_Q3: begin cmd.op = OP_MAC_CLR; cmd.msel = MS_QXX; state_d = S_Q4; end
			S_Q4: begin cmd.op = OP_MAC; cmd.msel = MS_QYY; state_d = S_QS2; end
			S_QS2: begin cmd.op = OP_FZ; state_d = S_AC; end
			S_AC: begin cmd.op = OP_ANG; cmd.asel = AS_CUR; state_d = S_ACW; end
			S_ACW: begin
				if (!sts.cordic_busy) begin cmd.op = OP_CUR; state_d = S_AD; end
			end
			S_AD: begin cmd.op = OP_ANG; cmd.asel = AS_DES; state_d = S_ADW; end
			S_ADW: begin
				if (!sts.cordic_busy) begin cmd.op = OP_DES; state_d = S_AP; end
			end
			S_AP: begin cmd.op = OP_ANG; cmd.asel = AS_PIT; state_d = S_APW; end
			S_APW: begin
				if (!sts.cordic_busy) begin cmd.op = OP_PIT; state_d = S_T1; end
			end
			S_T1: begin cmd.op = OP_TGT1; state_d = S_T2; end
			S_T2: begin cmd.op = OP_TGT2; state_d = S_T3; end
			S_T3: begin cmd.op = OP_TGT3; state_d = S_UPD; end
			S_UPD: begin
				if (out_free) begin cmd.op = OP_UPD; state_d = S_IDLE; end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_UPD) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_PREP))
		else $error("accepted word did not start the sequence");

	a_upd_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_UPD) |=> out_valid_q)
		else $error("result update did not present a word");

	a_word_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_UPD))
		else $error("result word appeared outside the update step");

endmodule

`default_nettype wire

// ===== rtl/core/waypoint_attitude_guidance.sv =====
// ----------------------------------------------------------------------------
// Waypoint attitude guidance
// Steers pitch, roll, yaw rate and throttle towards a configured waypoint.
// ----------------------------------------------------------------------------
// One input word (position, velocity, attitude quaternion, frame time) is taken
// at a time, and one result word follows it. Three square roots come from one
// shared root unit and three arctangents from one shared vectoring CORDIC, with
// 20 rotations and up to 29 single-bit normalisation shifts each; a zero vector
// skips the rotations and gives angle zero. Multiply-accumulate and target
// arithmetic steps complete each word. If the previous result is still held by
// the sink, the last step waits for it before the new result is written.
// in_stall is high while a word is being worked on. The result sits in an output
// register, so a new word is accepted while the previous result still waits for
// the sink.
// The waypoint registers may be written whenever the block is idle; cfg_ready is
// always high and an unknown index is ignored. Pitch, roll and throttle commands
// are held between words and slew towards their targets by rate times step_time.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_attitude_guidance
	import wag_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [19:0] vel_x,
	input  wire logic signed [19:0] vel_y,
	input  wire logic signed [19:0] vel_z,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic [12:0]        step_time,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [14:0]      pitch_out,
	output logic signed [14:0]      roll_out,
	output logic signed [14:0]      yaw_rate_out,
	output logic [15:0]             throttle_out,
	output logic [31:0]             distance_out,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Writes are to be made only while idle; the block itself does not enforce this, and the port never pushes back.
	assign cfg_ready = 1'b1;

	wag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	wag_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.quat_w       (quat_w),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.step_time    (step_time),
		.pitch_out    (pitch_out),
		.roll_out     (roll_out),
		.yaw_rate_out (yaw_rate_out),
		.throttle_out (throttle_out),
		.distance_out (distance_out)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Waypoint attitude guidance testbench
// Drives navigation words into the guidance block, predicts every command word
// with a bit-exact fixed-point model kept here, and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import wag_pkg::*;
();

	// The run limit allows for roughly a thousand words, each with its longest
	// gap and stall, and then several times that again.
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE      = 400;
	localparam int unsigned RANDOM_WORDS = 920;

	// Register index that addresses nothing.
	localparam logic [1:0] CFG_NO_REG = 2'd3;

	// Fixed-point constants of the guidance law.
	localparam longint PI_Q20      = 3294199;
	localparam longint HALF_PI_Q20 = 1647099;
	localparam longint ONE_METRE   = 256;
	localparam longint NEAR_RANGE  = 30720;
	localparam longint FAR_RANGE   = 307200;
	localparam longint FAST_SPEED  = 5120;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [19:0] vx, vy, vz;
		logic signed [15:0] qw, qx, qy, qz;
		logic [12:0]        dt;
	} nav_word_t;

	typedef struct {
		logic signed [14:0] pitch;
		logic signed [14:0] roll;
		logic signed [14:0] yaw_rate;
		logic [15:0]        throttle;
		logic [31:0]        distance;
	} cmd_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [19:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic [12:0]        step_time = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [14:0] pitch_out, roll_out, yaw_rate_out;
	logic [15:0]        throttle_out;
	logic [31:0]        distance_out;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// Predictor state: the waypoint and the slewed commands.
	longint    wp_x, wp_y, wp_z;
	longint    pitch_cmd, roll_cmd, thr_cmd;
	cmd_word_t expected_cmds[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit        calm = 1'b0;

	waypoint_attitude_guidance i_dut (
		.clk, .arst_n,
		.in_valid, .in_stall,
		.pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z,
		.quat_w, .quat_x, .quat_y, .quat_z, .step_time,
		.out_valid, .out_stall,
		.pitch_out, .roll_out, .yaw_rate_out, .throttle_out, .distance_out,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Fixed-point guidance model
	// ------------------------------------------------------------------

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_down_shift(longint v, int s);
		longint t;
		t = v + (longint'(1) << (s - 1));
		return t >>> s;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Euclidean length; while any component is 2^31 or more all are halved, and the
	// root is doubled as often afterwards, so the low bits are lost on huge offsets.
	function automatic longint unsigned vec_length(longint unsigned a, longint unsigned b,
			longint unsigned c);
		int s;
		s = 0;
		while ((a | b | c) >= 64'h8000_0000) begin
			a = a >> 1;
			b = b >> 1;
			c = c >> 1;
			s++;
		end
		return floor_root(a * a + b * b + c * c) << s;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// Four-quadrant arctangent in rad * 2^20 by 20-step vectoring.
	function automatic longint bearing(longint y, longint x);
		longint unsigned ax, ay;
		longint cx, cy, nx, z, r;
		ax = magnitude(x);
		ay = magnitude(y);
		z = 0;
		if (ax == 0 && ay == 0)
			return 0;
		while ((ax | ay) >= 64'h4000_0000) begin
			ax = ax >> 1;
			ay = ay >> 1;
		end
		while ((ax | ay) < 64'h2000_0000) begin
			ax = ax << 1;
			ay = ay << 1;
		end
		cx = longint'(ax);
		cy = longint'(ay);
		for (int i = 0; i < 20; i++) begin
			if (cy >= 0) begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z = z + longint'(atan_entry(5'(i)));
			end else begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z = z - longint'(atan_entry(5'(i)));
			end
			cx = nx;
		end
		z = clip(z, 0, HALF_PI_Q20);
		r = (x >= 0) ? z : PI_Q20 - z;
		return (y >= 0) ? r : -r;
	endfunction

	function automatic longint slewed(longint cur, longint target, longint step);
		return cur + clip(target - cur, -step, step);
	endfunction

	// Works out the command word for one accepted navigation word and moves
	// the held commands on.
	function automatic cmd_word_t predict_commands(nav_word_t w);
		longint dx, dy, dz, vx, vy, vz, qw, qx, qy, qz, dt;
		longint unsigned span_len, horiz, speed_sq, hd;
		longint speed, cur, des, err, pitch_t, roll_t, yaw_t, thr_t, ts, fx, fzn;
		cmd_word_t c;
		dx = wp_x - longint'(w.px);
		dy = wp_y - longint'(w.py);
		dz = wp_z - longint'(w.pz);
		vx = w.vx; vy = w.vy; vz = w.vz;
		qw = w.qw; qx = w.qx; qy = w.qy; qz = w.qz;
		dt = longint'({1'b0, w.dt});
		span_len = vec_length(magnitude(dx), magnitude(dy), magnitude(dz));
		horiz = vec_length(magnitude(dx), 0, magnitude(dz));
		speed_sq = longint'(vx * vx + vy * vy + vz * vz);
		speed = longint'(floor_root(speed_sq));

		// Above 20 m/s the flight path gives the heading, else the nose axis.
		if (speed_sq > FAST_SPEED * FAST_SPEED) begin
			cur = bearing(vx, -vz);
		end else begin
			fx = -2 * (qx * qz + qw * qy);
			fzn = (longint'(1) << 28) - 2 * (qx * qx + qy * qy);
			cur = bearing(fx, fzn);
		end
		des = bearing(dx, -dz);
		err = des - cur;
		if (err > PI_Q20) err = err - 2 * PI_Q20;
		if (err < -PI_Q20) err = err + 2 * PI_Q20;

		hd = horiz < ONE_METRE ? ONE_METRE : horiz;
		pitch_t = clip(round_down_shift(bearing(dy, longint'(hd)), 7), -1716, 1716);
		roll_t = clip(round_down_shift(err * 6554, 19), -5004, 5004);
		yaw_t = clip(round_down_shift(err * 4915, 19), -2002, 2002);
		ts = (span_len > FAR_RANGE) ? 48640 : 39680;
		thr_t = clip(18350 + round_down_shift((ts - speed) * 41943, 16), 11469, 29491);
		if (span_len < NEAR_RANGE) begin
			pitch_t = 0;
			roll_t = 0;
			yaw_t = 0;
			thr_t = 14746;
		end

		pitch_cmd = clip(slewed(pitch_cmd, pitch_t, (2574 * dt) >>> 16), -4289, 4289);
		roll_cmd = clip(slewed(roll_cmd, roll_t, (4003 * dt) >>> 16), -7149, 7149);
		thr_cmd = clip(slewed(thr_cmd, thr_t, (8192 * dt) >>> 16), 0, 32768);

		c.pitch = 15'(pitch_cmd);
		c.roll = 15'(roll_cmd);
		c.yaw_rate = 15'(yaw_t);
		c.throttle = 16'(thr_cmd);
		c.distance = span_len > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(span_len);
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Sending and checking
	// ------------------------------------------------------------------

	// Sends one word after a random gap. Valid is left high after acceptance so
	// that a back-to-back word never lowers and raises it in one time step.
	task automatic send_word(nav_word_t w);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
		vel_x <= w.vx; vel_y <= w.vy; vel_z <= w.vz;
		quat_w <= w.qw; quat_x <= w.qx; quat_y <= w.qy; quat_z <= w.qz;
		step_time <= w.dt;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_cmds.push_back(predict_commands(w));
	endtask

	// Lowers valid and waits until every expected result has come back.
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
	endtask

	// Register writes happen only with the block idle; the settle time covers
	// anything still moving inside after the last result.
	task automatic write_waypoint(logic [1:0] idx, logic [31:0] value);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WP_X: wp_x = longint'(signed'(value));
			CFG_WP_Y: wp_y = longint'(signed'(value));
			CFG_WP_Z: wp_z = longint'(signed'(value));
			default: ;
		endcase
	endtask

	// Outside the calm stretch the sink may stall for a random number of cycles after each accepted word.
	always begin
		int unsigned hold;
		@(posedge clk);
		if (out_valid && !out_stall) begin
			hold = calm ? 0 : $urandom_range(0, 8);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Every accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		cmd_word_t e;
		if (out_valid && !out_stall) begin
			if (expected_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result word with nothing expected: dist %0d", distance_out);
			end else begin
				e = expected_cmds.pop_front();
				if (pitch_out !== e.pitch || roll_out !== e.roll ||
						yaw_rate_out !== e.yaw_rate || throttle_out !== e.throttle ||
						distance_out !== e.distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected p %0d r %0d y %0d t %0d d %0d,",
							" got p %0d r %0d y %0d t %0d d %0d"},
							e.pitch, e.roll, e.yaw_rate, e.throttle, e.distance,
							pitch_out, roll_out, yaw_rate_out, throttle_out, distance_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic longint spread(longint lim);
		return longint'($urandom_range(0, 32'(2 * lim))) - lim;
	endfunction

	// A word a given distance band from the waypoint, with random content.
	function automatic nav_word_t shaped_word(longint reach);
		nav_word_t w;
		w.px = 32'(wp_x - spread(reach));
		w.py = 32'(wp_y - spread(reach));
		w.pz = 32'(wp_z - spread(reach));
		if ($urandom_range(0, 1)) begin
			w.vx = 20'(spread(5000)); w.vy = 20'(spread(2000)); w.vz = 20'(spread(5000));
		end else begin
			w.vx = 20'(spread(524287)); w.vy = 20'(spread(100000));
			w.vz = 20'(spread(524287));
		end
		w.qw = 16'(spread(16384)); w.qx = 16'(spread(16384));
		w.qy = 16'(spread(16384)); w.qz = 16'(spread(16384));
		w.dt = 13'($urandom_range(0, 6554));
		return w;
	endfunction

	function automatic nav_word_t noise_word;
		nav_word_t w;
		w.px = $urandom; w.py = $urandom; w.pz = $urandom;
		w.vx = 20'($urandom); w.vy = 20'($urandom); w.vz = 20'($urandom);
		w.qw = 16'($urandom); w.qx = 16'($urandom);
		w.qy = 16'($urandom); w.qz = 16'($urandom);
		w.dt = 13'($urandom);
		return w;
	endfunction

	// A word at the waypoint, level, stationary and upright, with full frame time.
	function automatic nav_word_t plain_word;
		nav_word_t w;
		w.px = 32'(wp_x); w.py = 32'(wp_y); w.pz = 32'(wp_z);
		w.vx = '0; w.vy = '0; w.vz = '0;
		w.qw = 16'sd16384; w.qx = '0; w.qy = '0; w.qz = '0;
		w.dt = 13'd6554;
		return w;
	endfunction

	// Default waypoint, words from each distance band.
	task automatic test_default_waypoint;
		nav_word_t w;
		w = plain_word();
		send_word(w);
		w.px = 32'(wp_x - 2000 * ONE_METRE);
		send_word(w);
		w.px = 32'(wp_x - 500 * ONE_METRE);
		send_word(w);
		w.px = 32'(wp_x - 119 * ONE_METRE);
		send_word(w);
	endtask

	// Extremes of every input field, zero and overlong frame times.
	task automatic test_field_extremes;
		nav_word_t w;
		w = plain_word();
		w.px = 32'h8000_0000; w.py = 32'h7FFF_FFFF; w.pz = 32'h8000_0000;
		w.vx = 20'h80000; w.vy = 20'h7FFFF; w.vz = 20'h80000;
		w.dt = 13'd8191;
		send_word(w);
		w.px = 32'h7FFF_FFFF; w.py = 32'h8000_0000; w.pz = 32'h7FFF_FFFF;
		w.vx = 20'h7FFFF; w.vy = 20'h80000; w.vz = 20'h7FFFF;
		w.qw = 16'h8000; w.qx = 16'h7FFF; w.qy = 16'h8000; w.qz = 16'h7FFF;
		w.dt = 13'd0;
		send_word(w);
		w.qw = 16'h7FFF; w.qx = 16'h8000; w.qy = 16'h7FFF; w.qz = 16'h8000;
		w.dt = 13'd6554;
		send_word(w);
	endtask

	// Heading source at the 20 m/s boundary and a degenerate quaternion.
	task automatic test_heading_source;
		nav_word_t w;
		w = plain_word();
		w.px = 32'(wp_x - 3000 * ONE_METRE);
		w.vx = 20'sd5120;
		w.qw = 16'sd11585; w.qy = 16'sd11585;
		send_word(w);
		w.vx = 20'sd5121;
		send_word(w);
		w.vx = '0; w.vz = -20'sd5121;
		send_word(w);
		w.vz = '0;
		w.qw = '0; w.qx = '0; w.qy = '0; w.qz = '0;
		send_word(w);
		// Forward axis straight up: both arctangent inputs vanish.
		w.qx = 16'sd8192; w.qy = 16'sd8192; w.qw = '0; w.qz = '0;
		send_word(w);
		// Target dead ahead on the nose axis: heading error near zero.
		w.qw = 16'sd16384; w.qx = '0; w.qy = '0;
		w.pz = 32'(wp_z + 3000 * ONE_METRE);
		send_word(w);
		w.px = 32'(wp_x + 1); w.dt = 13'd6554;
		send_word(w);
	endtask

	// Pitch target with horizontal distance below one metre.
	task automatic test_vertical_target;
		nav_word_t w;
		w = plain_word();
		w.py = 32'(wp_y - 200 * ONE_METRE);
		send_word(w);
		w.py = 32'(wp_y + 200 * ONE_METRE);
		w.px = 32'(wp_x - 100);
		send_word(w);
	endtask

	// Waypoint registers at their extremes, plus an unknown index.
	task automatic test_waypoint_registers;
		write_waypoint(CFG_WP_X, 32'h8000_0000);
		write_waypoint(CFG_WP_Y, 32'h7FFF_FFFF);
		write_waypoint(CFG_WP_Z, 32'h7FFF_FFFF);
		write_waypoint(CFG_NO_REG, 32'h1234_5678);
		send_word(shaped_word(1000000));
		send_word(noise_word());
		send_word(plain_word());
		write_waypoint(CFG_WP_X, 32'h7FFF_FFFF);
		write_waypoint(CFG_WP_Y, 32'h8000_0000);
		write_waypoint(CFG_WP_Z, 32'h8000_0000);
		send_word(noise_word());
		send_word(plain_word());
		write_waypoint(CFG_WP_X, '0);
		write_waypoint(CFG_WP_Y, '0);
		write_waypoint(CFG_WP_Z, '0);
		send_word(plain_word());
	endtask

	// Mostly words placed in one of the distance bands around a random waypoint, with some
	// raw noise; one calm stretch, and one full pause besides those at each waypoint change.
	task automatic test_random_flight;
		nav_word_t w;
		int unsigned pick;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 230 == 229) begin
				write_waypoint(CFG_WP_X, 32'(spread(1 << 28)));
				write_waypoint(CFG_WP_Y, 32'(spread(1 << 22)));
				write_waypoint(CFG_WP_Z, 32'(spread(1 << 28)));
			end
			if (n == 300) calm = 1'b1;
			if (n == 360) calm = 1'b0;
			if (n == 500) drain();
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1: w = shaped_word(20000);
				2, 3: w = shaped_word(200000);
				4, 5, 6: w = shaped_word(600000);
				7: w = shaped_word(1 << 30);
				default: w = noise_word();
			endcase
			send_word(w);
		end
	endtask

	initial begin
		wp_x = longint'(WP_X_RST);
		wp_y = longint'(WP_Y_RST);
		wp_z = longint'(WP_Z_RST);
		pitch_cmd = 0;
		roll_cmd = 0;
		thr_cmd = longint'(THR_RST);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_waypoint();
		test_field_extremes();
		test_heading_source();
		test_vertical_target();
		test_waypoint_registers();
		test_random_flight();

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/wag_pkg.sv
rtl/core/wag_sqrt.sv
rtl/core/wag_cordic.sv
rtl/core/wag_dp.sv
rtl/core/wag_ctrl.sv
rtl/core/waypoint_attitude_guidance.sv
tb/testbench.sv
